[sv/twcm_pkg.sv]
package twcm_pkg;

	// Texture geometry: four faces, TEX_SIZE x TEX_SIZE words each
	localparam int TEX_BITS  = 6;
	localparam int FRAC_BITS = 16;
	localparam int FACE_BITS = 2;
	localparam int ADDR_W    = FACE_BITS + 2 * TEX_BITS;
	localparam int TEX_WORDS = 1 << ADDR_W;

	// Step division: dividend is TEX_SIZE in fixed point, a single set bit
	localparam int DIV_W = TEX_BITS + FRAC_BITS + 1;
	localparam int DIVISOR_W = 16;
	localparam int REM_W = DIVISOR_W + 1;
	localparam int CNT_W = $clog2(DIV_W + 1);

	// d = 2*first_row - scr_rows - 2*view_pitch fits 14 bits signed
	localparam int DIFF_W = 14;
	localparam int PROD_W = DIFF_W + DIV_W + 1;

	localparam int ROW_W   = 11;
	localparam int COLOR_W = 32;
	localparam int SH_W    = 12;

	localparam logic [COLOR_W-1:0] SHADE_MASK = 32'h007F_7F7F;
	localparam logic [31:0] HALF_SIZE = 32'(1) << (TEX_BITS + FRAC_BITS - 1);

	localparam logic [SH_W-1:0] SCR_ROWS_RST = 12'd720;

	// Opcodes carried in s_axis_tuser
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_EMIT  = 2'd2;

	localparam int IN_DATA_W  = 104;
	localparam int OUT_DATA_W = 48;

endpackage

[sv/textured_wall_column_mapper_core.sv]
// Channel   Dir  Payload                                      Marks
// s_axis    in   tdata: texel/column/pixel fields (98 bits)   tuser: opcode
// m_axis    out  tdata: pixel_row, pixel_color (43 bits)      tlast: last_row
// cfg       in   cfg_wdata: screen rows                       cfg_we strobe
//
// Texel write: stored on accept. Emit: texture read, then registered read data loaded
// into the output register, held back only while the sink still holds that register.
// Column start: accept, 23 steps of the shared restoring divider, one multiply,
// one add; a zero wall height skips the divider and goes straight to the multiply.
// arst_n clears control state and sets the screen rows to 720; the texture
// memory is not cleared. s_axis_tready is high only when the sequencer is idle.
module textured_wall_column_mapper_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// texel_face, texel_row, tex_col, texel_color, vertical_side, dir_x_positive,
	// dir_y_positive, wall_line_height, first_row, final_row, view_pitch, zero pad
	input  logic [twcm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// opcode
	input  logic [1:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pixel_row, pixel_color, zero pad
	output logic [twcm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// last_row
	output logic                              m_axis_tlast,
	input  logic                              cfg_we,
	input  logic [twcm_pkg::SH_W-1:0]         cfg_wdata
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_POS  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;

	// Unpack the input item
	logic [1:0]  in_face;
	logic [5:0]  in_row;
	logic [5:0]  in_col;
	logic [31:0] in_color;
	logic        in_vert;
	logic        in_dxp;
	logic        in_dyp;
	logic [15:0] in_height;
	logic [10:0] in_first;
	logic [10:0] in_final;
	logic [10:0] in_pitch;

	assign in_face   = s_axis_tdata[1:0];
	assign in_row    = s_axis_tdata[7:2];
	assign in_col    = s_axis_tdata[13:8];
	assign in_color  = s_axis_tdata[45:14];
	assign in_vert   = s_axis_tdata[46];
	assign in_dxp    = s_axis_tdata[47];
	assign in_dyp    = s_axis_tdata[48];
	assign in_height = s_axis_tdata[64:49];
	assign in_first  = s_axis_tdata[75:65];
	assign in_final  = s_axis_tdata[86:76];
	assign in_pitch  = s_axis_tdata[97:87];

	logic [2:0] state_q;
	logic [twcm_pkg::SH_W-1:0] scr_rows_q;

	logic [31:0] tex_pos_q;
	logic [31:0] tex_step_q;
	logic [twcm_pkg::ROW_W-1:0] cur_row_q;
	logic [twcm_pkg::ROW_W-1:0] end_row_q;
	logic active_q;
	logic [twcm_pkg::FACE_BITS-1:0] face_q;
	logic [twcm_pkg::TEX_BITS-1:0] col_q;
	logic shade_q;

	// Shared divider and multiply registers
	logic [twcm_pkg::DIVISOR_W-1:0] height_q;
	logic [twcm_pkg::REM_W-1:0] rem_q;
	logic [twcm_pkg::DIV_W-1:0] quo_q;
	logic [twcm_pkg::CNT_W-1:0] div_cnt_q;
	logic signed [twcm_pkg::DIFF_W-1:0] diff_q;
	logic signed [twcm_pkg::PROD_W-1:0] prod_q;

	// Pending emit and output register
	logic [twcm_pkg::ROW_W-1:0] pend_row_q;
	logic pend_last_q;
	logic pend_shade_q;
	logic [twcm_pkg::COLOR_W-1:0] rd_data_q;
	logic out_valid_q;
	logic [twcm_pkg::ROW_W-1:0] out_row_q;
	logic [twcm_pkg::COLOR_W-1:0] out_color_q;
	logic out_last_q;

	logic in_acc;
	logic acc_write;
	logic acc_start;
	logic acc_emit;
	logic out_load;
	logic [twcm_pkg::ADDR_W-1:0] wr_addr;
	logic [twcm_pkg::ADDR_W-1:0] rd_addr;
	logic [twcm_pkg::REM_W-1:0] rem_sh;
	logic rem_ge;
	logic signed [twcm_pkg::DIFF_W-1:0] diff_next;
	logic [twcm_pkg::COLOR_W-1:0] shaded;

	logic [twcm_pkg::COLOR_W-1:0] tex_mem [twcm_pkg::TEX_WORDS];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign acc_write = in_acc && (s_axis_tuser == twcm_pkg::OP_WRITE);
	assign acc_start = in_acc && (s_axis_tuser == twcm_pkg::OP_START);
	// An emit with no active column, or past the final row, gives nothing
	assign acc_emit  = in_acc && (s_axis_tuser == twcm_pkg::OP_EMIT) && active_q &&
		(cur_row_q <= end_row_q);

	assign out_load = (state_q == ST_RD) && (!out_valid_q || m_axis_tready);

	assign wr_addr = {in_face, in_row, in_col};
	assign rd_addr = {face_q, tex_pos_q[twcm_pkg::FRAC_BITS +: twcm_pkg::TEX_BITS], col_q};

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh = {rem_q[twcm_pkg::REM_W-2:0], quo_q[twcm_pkg::DIV_W-1]};
	assign rem_ge = (rem_sh >= {1'b0, height_q});

	assign diff_next = $signed({2'b00, in_first, 1'b0})
		- $signed({2'b00, scr_rows_q})
		- $signed({{2{in_pitch[10]}}, in_pitch, 1'b0});

	// Vertical hits: halve each byte, top byte dropped
	assign shaded = pend_shade_q ? ((rd_data_q >> 1) & twcm_pkg::SHADE_MASK) : rd_data_q;

	// Texture memory: one write or one read per cycle, read data registered
	always_ff @(posedge clk) begin
		if (acc_write) begin
			tex_mem[wr_addr] <= in_color;
		end else if (acc_emit) begin
			rd_data_q <= tex_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_rows_q <= twcm_pkg::SCR_ROWS_RST;
		end else if (cfg_we) begin
			scr_rows_q <= cfg_wdata;
		end
	end

	// Sequencer and column state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tex_pos_q  <= '0;
			tex_step_q <= '0;
			cur_row_q  <= '0;
			end_row_q  <= '0;
			active_q   <= 1'b0;
			face_q     <= '0;
			col_q      <= '0;
			shade_q    <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc_start) begin
						if (in_vert) begin
							face_q <= in_dxp ? 2'd0 : 2'd1;
						end else begin
							face_q <= in_dyp ? 2'd2 : 2'd3;
						end
						shade_q   <= in_vert;
						col_q     <= in_col[twcm_pkg::TEX_BITS-1:0];
						cur_row_q <= in_first;
						end_row_q <= in_final;
						active_q  <= (in_first <= in_final);
						div_cnt_q <= twcm_pkg::CNT_W'(twcm_pkg::DIV_W);
						// Zero height gives a zero step: skip the divider
						state_q   <= (in_height == '0) ? ST_MUL : ST_DIV;
					end else if (acc_emit) begin
						tex_pos_q <= tex_pos_q + tex_step_q;
						if (cur_row_q == end_row_q) begin
							active_q <= 1'b0;
						end else begin
							cur_row_q <= cur_row_q + 1'b1;
						end
						state_q <= ST_RD;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == twcm_pkg::CNT_W'(1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					tex_step_q <= 32'(quo_q);
					state_q    <= ST_POS;
				end
				ST_POS: begin
					tex_pos_q <= twcm_pkg::HALF_SIZE + prod_q[32:1];
					state_q   <= ST_IDLE;
				end
				ST_RD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider datapath and multiply; no reset needed
	always_ff @(posedge clk) begin
		if (acc_start) begin
			height_q <= in_height;
			rem_q    <= '0;
			// Dividend TEX_SIZE << FRAC_BITS; zero when the divider is skipped
			quo_q    <= (in_height == '0) ? '0 :
				(twcm_pkg::DIV_W'(1) << (twcm_pkg::TEX_BITS + twcm_pkg::FRAC_BITS));
			diff_q   <= diff_next;
		end else if (state_q == ST_DIV) begin
			if (rem_ge) begin
				rem_q <= rem_sh - {1'b0, height_q};
				quo_q <= {quo_q[twcm_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[twcm_pkg::DIV_W-2:0], 1'b0};
			end
		end
		if (state_q == ST_MUL) begin
			prod_q <= twcm_pkg::PROD_W'(diff_q * $signed({1'b0, quo_q}));
		end
		if (acc_emit) begin
			pend_row_q   <= cur_row_q;
			pend_last_q  <= (cur_row_q == end_row_q);
			pend_shade_q <= shade_q;
		end
	end

	// Output register: hold until taken, refill from the pending read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= pend_row_q;
			out_color_q <= shaded;
			out_last_q  <= pend_last_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_color_q, out_row_q};
	assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_active_rows: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cur_row_q <= end_row_q))
		else $error("active column past its final row");

	a_emit_reads: assert property (@(posedge clk) disable iff (!arst_n)
		acc_emit |=> (state_q == ST_RD))
		else $error("emit did not start a texture read");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < {1'b0, height_q}))
		else $error("divider remainder not below divisor");

	a_div_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (div_cnt_q == twcm_pkg::CNT_W'(1)) |=> (state_q == ST_MUL))
		else $error("divider did not hand off to multiply");
`endif

endmodule
